/* rtl/core/gcdlcm_pkg.sv */
// Package for the gcd/lcm unit: datapath operation codes, controller states,
// command/status structs and the width mask helpers.
// No dependencies.
package gcdlcm_pkg;

   // width of the operand and result ports
   localparam int PORT_W  = 64;
   localparam int WCODE_W = 2;

   // width codes
   localparam logic [WCODE_W-1:0] WCODE_8  = 2'd0;
   localparam logic [WCODE_W-1:0] WCODE_16 = 2'd1;
   localparam logic [WCODE_W-1:0] WCODE_32 = 2'd2;
   localparam logic [WCODE_W-1:0] WCODE_64 = 2'd3;

   // operation kinds
   localparam logic KIND_GCD = 1'b0;
   localparam logic KIND_LCM = 1'b1;

   typedef enum logic [3:0] {
      OP_HOLD,
      OP_LOAD,
      OP_GCD,
      OP_FOLD,
      OP_SHIFT,
      OP_DIV_INIT,
      OP_DIV,
      OP_MUL_INIT,
      OP_MUL,
      OP_FINISH
   } dp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_SHIFT,
      ST_DIV,
      ST_MULI,
      ST_MUL,
      ST_FIN,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic gcd_done;   // one of the two gcd operands has reached zero
      logic k_zero;     // no common factor of two left to restore
      logic is_lcm;
      logic lcm_zero;   // an operand of the current word is zero
   } dp_status_type;

   // mask of the low bits that a width code selects
   function automatic logic [PORT_W-1:0] width_mask(input logic [WCODE_W-1:0] wc);
      logic [PORT_W-1:0] m;
      begin
         case (wc)
            WCODE_8:  m = 64'h0000_0000_0000_00FF;
            WCODE_16: m = 64'h0000_0000_0000_FFFF;
            WCODE_32: m = 64'h0000_0000_FFFF_FFFF;
            WCODE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
         return m;
      end
   endfunction

   // sign bit position of a width code
   function automatic logic [PORT_W-1:0] top_bit(input logic [WCODE_W-1:0] wc);
      logic [PORT_W-1:0] t;
      begin
         case (wc)
            WCODE_8:  t = 64'h0000_0000_0000_0080;
            WCODE_16: t = 64'h0000_0000_0000_8000;
            WCODE_32: t = 64'h0000_0000_8000_0000;
            WCODE_64: t = 64'h8000_0000_0000_0000;
            default:  t = 64'h8000_0000_0000_0000;
         endcase
         return t;
      end
   endfunction

endpackage

/* rtl/core/gcdlcm_ctrl.sv */
// Controller of the gcd/lcm unit: sequences load, binary gcd, restore shift,
// division and multiplication. Depends on gcdlcm_pkg.
module gcdlcm_ctrl #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_strobe,
   output gcdlcm_pkg::dp_cmd_type    cmd,
   input  gcdlcm_pkg::dp_status_type status
);

   localparam int CNT_W = $clog2(MAX_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_WIDTH - 1);

   gcdlcm_pkg::ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcdlcm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.op     = gcdlcm_pkg::OP_HOLD;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         gcdlcm_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op   = gcdlcm_pkg::OP_LOAD;
               state_in = gcdlcm_pkg::ST_GCD;
            end
         end
         gcdlcm_pkg::ST_OUT: begin
            // result shown for one cycle; next word may be taken alongside
            busy       = 1'b0;
            rsp_strobe = 1'b1;
            if (start) begin
               cmd.op   = gcdlcm_pkg::OP_LOAD;
               state_in = gcdlcm_pkg::ST_GCD;
            end else begin
               state_in = gcdlcm_pkg::ST_IDLE;
            end
         end
         gcdlcm_pkg::ST_GCD: begin
            if (status.gcd_done) begin
               cmd.op   = gcdlcm_pkg::OP_FOLD;
               state_in = gcdlcm_pkg::ST_SHIFT;
            end else begin
               cmd.op = gcdlcm_pkg::OP_GCD;
            end
         end
         gcdlcm_pkg::ST_SHIFT: begin
            if (!status.k_zero) begin
               cmd.op = gcdlcm_pkg::OP_SHIFT;
            end else if (status.is_lcm && !status.lcm_zero) begin
               cmd.op   = gcdlcm_pkg::OP_DIV_INIT;
               cnt_in   = LAST_STEP;
               state_in = gcdlcm_pkg::ST_DIV;
            end else begin
               cmd.op   = gcdlcm_pkg::OP_FINISH;
               state_in = gcdlcm_pkg::ST_OUT;
            end
         end
         gcdlcm_pkg::ST_DIV: begin
            cmd.op = gcdlcm_pkg::OP_DIV;
            if (cnt_ff == '0) begin
               state_in = gcdlcm_pkg::ST_MULI;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         gcdlcm_pkg::ST_MULI: begin
            cmd.op   = gcdlcm_pkg::OP_MUL_INIT;
            cnt_in   = LAST_STEP;
            state_in = gcdlcm_pkg::ST_MUL;
         end
         gcdlcm_pkg::ST_MUL: begin
            cmd.op = gcdlcm_pkg::OP_MUL;
            if (cnt_ff == '0) begin
               state_in = gcdlcm_pkg::ST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         gcdlcm_pkg::ST_FIN: begin
            cmd.op   = gcdlcm_pkg::OP_FINISH;
            state_in = gcdlcm_pkg::ST_OUT;
         end
         default: begin
            state_in = gcdlcm_pkg::ST_IDLE;
         end
      endcase
   end

   // an accepted word is never answered in the following cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("result strobe directly after accept");

   // strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // division is entered only from the restore shift
   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcdlcm_pkg::ST_DIV) |->
         ($past(state_ff) == gcdlcm_pkg::ST_SHIFT || $past(state_ff) == gcdlcm_pkg::ST_DIV))
      else $error("division entered out of sequence");

endmodule

/* rtl/core/gcdlcm_dpath.sv */
// Datapath of the gcd/lcm unit: operand magnitudes, binary gcd, restoring
// divider, shift-add multiplier and result saturation. Depends on gcdlcm_pkg.
module gcdlcm_dpath #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gcdlcm_pkg::dp_cmd_type                cmd,
   output gcdlcm_pkg::dp_status_type             status,
   input  logic                                 req_kind,
   input  logic                                 req_is_signed,
   input  logic [gcdlcm_pkg::WCODE_W-1:0]       req_width_code,
   input  logic [gcdlcm_pkg::PORT_W-1:0]        req_operand_a,
   input  logic [gcdlcm_pkg::PORT_W-1:0]        req_operand_b,
   output logic [gcdlcm_pkg::PORT_W-1:0]        rsp_result_value
);

   localparam int DW = MAX_WIDTH;
   localparam int KW = $clog2(DW);
   // widest width code that fits the datapath
   localparam logic [gcdlcm_pkg::WCODE_W-1:0] MAX_CODE =
      (DW >= 64) ? gcdlcm_pkg::WCODE_64 :
      (DW >= 32) ? gcdlcm_pkg::WCODE_32 :
      (DW >= 16) ? gcdlcm_pkg::WCODE_16 : gcdlcm_pkg::WCODE_8;

   // word attributes
   logic                               kind_ff, sgn_ff, na_ff, nb_ff, lcm_zero_ff;
   logic [gcdlcm_pkg::WCODE_W-1:0]     wc_ff;
   // gcd, divider and multiplier registers
   logic [DW-1:0]                      x_ff, y_ff, g_ff, ma_ff, mb_ff;
   logic [KW-1:0]                      k_ff;
   logic [DW-1:0]                      q_ff, r_ff, p_hi_ff, p_lo_ff;
   logic [gcdlcm_pkg::PORT_W-1:0]      res_ff;

   // operand load
   logic [gcdlcm_pkg::WCODE_W-1:0]     wc_eff;
   logic [gcdlcm_pkg::PORT_W-1:0]      ld_mask, ld_top, a64, b64, ma64, mb64;
   logic                               ld_na, ld_nb;

   always_comb begin
      wc_eff  = (req_width_code > MAX_CODE) ? MAX_CODE : req_width_code;
      ld_mask = gcdlcm_pkg::width_mask(wc_eff);
      ld_top  = gcdlcm_pkg::top_bit(wc_eff);
      a64     = req_operand_a & ld_mask;
      b64     = req_operand_b & ld_mask;
      ld_na   = req_is_signed & (|(a64 & ld_top));
      ld_nb   = req_is_signed & (|(b64 & ld_top));
      ma64    = ld_na ? ((64'd0 - a64) & ld_mask) : a64;
      mb64    = ld_nb ? ((64'd0 - b64) & ld_mask) : b64;
   end

   // binary gcd step
   logic [DW-1:0] x_gcd, y_gcd;
   logic          k_inc;

   always_comb begin
      x_gcd = x_ff;
      y_gcd = y_ff;
      k_inc = 1'b0;
      if (!x_ff[0] && !y_ff[0]) begin
         x_gcd = x_ff >> 1;
         y_gcd = y_ff >> 1;
         k_inc = 1'b1;
      end else if (!x_ff[0]) begin
         x_gcd = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_gcd = y_ff >> 1;
      end else if (x_ff >= y_ff) begin
         x_gcd = (x_ff - y_ff) >> 1;
      end else begin
         y_gcd = (y_ff - x_ff) >> 1;
      end
   end

   // restoring division step
   logic [DW:0]   div_shift, div_diff;
   logic          div_fit;

   always_comb begin
      div_shift = {r_ff, q_ff[DW-1]};
      div_diff  = div_shift - {1'b0, g_ff};
      div_fit   = (div_shift >= {1'b0, g_ff});
   end

   // shift-add multiplication step
   logic [DW:0]   mul_sum;

   always_comb begin
      mul_sum = {1'b0, p_hi_ff} + (p_lo_ff[0] ? {1'b0, mb_ff} : '0);
   end

   // result: saturation of the lcm product, sign extension at the width
   logic [gcdlcm_pkg::PORT_W-1:0]      fin_mask64, fin_top64, res64, out64;
   logic [DW-1:0]                      mask_dw, top_dw, limit, prod, lcm_res, res_dw;
   logic                               ng, neg, over;

   always_comb begin
      fin_mask64 = gcdlcm_pkg::width_mask(wc_ff);
      fin_top64  = gcdlcm_pkg::top_bit(wc_ff);
      mask_dw    = fin_mask64[DW-1:0];
      top_dw     = fin_top64[DW-1:0];
      ng         = sgn_ff & (|(g_ff & top_dw));
      neg        = sgn_ff & (na_ff ^ ng ^ nb_ff);
      limit      = sgn_ff ? (neg ? top_dw : (top_dw - 1'b1)) : mask_dw;
      over       = (|p_hi_ff) || (p_lo_ff > limit);
      prod       = neg ? ((-p_lo_ff) & mask_dw) : p_lo_ff;
      lcm_res    = over ? limit : prod;
      if (kind_ff == gcdlcm_pkg::KIND_GCD) begin
         res_dw = g_ff & mask_dw;
      end else if (lcm_zero_ff) begin
         res_dw = '0;
      end else begin
         res_dw = lcm_res;
      end
      res64 = 64'(res_dw);
      out64 = (sgn_ff && (|(res64 & fin_top64))) ? (res64 | ~fin_mask64) : res64;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         gcdlcm_pkg::OP_LOAD: begin
            kind_ff     <= req_kind;
            sgn_ff      <= req_is_signed;
            wc_ff       <= wc_eff;
            na_ff       <= ld_na;
            nb_ff       <= ld_nb;
            ma_ff       <= ma64[DW-1:0];
            mb_ff       <= mb64[DW-1:0];
            x_ff        <= ma64[DW-1:0];
            y_ff        <= mb64[DW-1:0];
            k_ff        <= '0;
            lcm_zero_ff <= (a64 == 64'd0) || (b64 == 64'd0);
         end
         gcdlcm_pkg::OP_GCD: begin
            x_ff <= x_gcd;
            y_ff <= y_gcd;
            if (k_inc) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         gcdlcm_pkg::OP_FOLD: begin
            // one of the two is zero
            g_ff <= x_ff | y_ff;
         end
         gcdlcm_pkg::OP_SHIFT: begin
            g_ff <= g_ff << 1;
            k_ff <= k_ff - 1'b1;
         end
         gcdlcm_pkg::OP_DIV_INIT: begin
            q_ff <= ma_ff;
            r_ff <= '0;
         end
         gcdlcm_pkg::OP_DIV: begin
            if (div_fit) begin
               r_ff <= div_diff[DW-1:0];
               q_ff <= {q_ff[DW-2:0], 1'b1};
            end else begin
               r_ff <= div_shift[DW-1:0];
               q_ff <= {q_ff[DW-2:0], 1'b0};
            end
         end
         gcdlcm_pkg::OP_MUL_INIT: begin
            p_lo_ff <= q_ff;
            p_hi_ff <= '0;
         end
         gcdlcm_pkg::OP_MUL: begin
            p_hi_ff <= mul_sum[DW:1];
            p_lo_ff <= {mul_sum[0], p_lo_ff[DW-1:1]};
         end
         gcdlcm_pkg::OP_FINISH: begin
            res_ff <= out64;
         end
         default: begin
         end
      endcase
   end

   assign status.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign status.k_zero   = (k_ff == '0);
   assign status.is_lcm   = (kind_ff == gcdlcm_pkg::KIND_LCM);
   assign status.lcm_zero = lcm_zero_ff;
   assign rsp_result_value = res_ff;

   // the divisor of an lcm is a nonzero gcd
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gcdlcm_pkg::OP_DIV) |-> (g_ff != '0))
      else $error("division by a zero gcd");

endmodule

/* rtl/core/gcd_lcm_unit_core.sv */
// Top level of the gcd/lcm unit: controller plus datapath.
// Depends on gcdlcm_pkg, gcdlcm_ctrl and gcdlcm_dpath.
//
// A word is taken when start is high and busy is low; exactly one result
// follows, shown on rsp_result_value for the single cycle in which rsp_strobe
// is high, and the receiver must take it then. Work is one word at a time:
// load, binary gcd one subtract-or-halve step per cycle (at most 2*W steps
// for width W) and a fold, then one shift per common factor of two
// restored, then finish. An lcm with nonzero operands adds a restoring
// divider of MAX_WIDTH steps and a shift-add multiplier of MAX_WIDTH
// steps. busy drops in the strobe cycle, so the next word can be taken
// while a result is shown.
module gcd_lcm_unit_core #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic                               req_is_signed,
   input  logic [gcdlcm_pkg::WCODE_W-1:0]     req_width_code,
   input  logic [gcdlcm_pkg::PORT_W-1:0]      req_operand_a,
   input  logic [gcdlcm_pkg::PORT_W-1:0]      req_operand_b,
   output logic                               rsp_strobe,
   output logic [gcdlcm_pkg::PORT_W-1:0]      rsp_result_value
);

   gcdlcm_pkg::dp_cmd_type    cmd;
   gcdlcm_pkg::dp_status_type status;

   gcdlcm_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   gcdlcm_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_is_signed    (req_is_signed),
      .req_width_code   (req_width_code),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_result_value (rsp_result_value)
   );

endmodule

/* tb/gcd_lcm_unit_core_tb.sv */
// Self-checking testbench for gcd_lcm_unit_core: a directed table, then random words.
// Every result is checked against the typed table value or a behavioural gcd/lcm calculation held here.
// Depends on gcdlcm_pkg and gcd_lcm_unit_core.
module gcd_lcm_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_WORDS = 1800;
   localparam int          SHOWN_ERRORS = 10;
   localparam int          SETTLE_CYCLES = 50;
   localparam longint      RUN_LIMIT_NS = 40_000_000;
   localparam logic        TYPED = 1'b1;
   localparam logic        PREDICT = 1'b0;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_kind;
   logic                                req_is_signed;
   logic [gcdlcm_pkg::WCODE_W-1:0]      req_width_code;
   logic [gcdlcm_pkg::PORT_W-1:0]       req_operand_a;
   logic [gcdlcm_pkg::PORT_W-1:0]       req_operand_b;
   logic                                rsp_strobe;
   logic [gcdlcm_pkg::PORT_W-1:0]       rsp_result_value;

   logic [gcdlcm_pkg::PORT_W-1:0]       pending_results[$];
   int                                  fail_count;
   logic [gcdlcm_pkg::PORT_W-1:0]       wanted;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic                             kind;
      logic                             sgn;
      logic [gcdlcm_pkg::WCODE_W-1:0]   wc;
      logic [gcdlcm_pkg::PORT_W-1:0]    a;
      logic [gcdlcm_pkg::PORT_W-1:0]    b;
      logic                             typed;
      logic [gcdlcm_pkg::PORT_W-1:0]    want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // zero operands
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_8,  64'd0,  64'd0,  TYPED, 64'd0},
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_8,  64'd12, 64'd0,  TYPED, 64'd12},
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_16, 64'd0,  64'd18, TYPED, 64'd18},
      '{gcdlcm_pkg::KIND_LCM, 1'b0, gcdlcm_pkg::WCODE_32, 64'd0,  64'd5,  TYPED, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_64, 64'd7,  64'd0,  TYPED, 64'd0},
      // all ones
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_8,  64'hFF, 64'hFF, TYPED, 64'hFF},
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_64, '1,     '1,     TYPED, '1},
      // signed minimum operands and a gcd of 2^(w-1)
      '{gcdlcm_pkg::KIND_GCD, 1'b1, gcdlcm_pkg::WCODE_8,  64'h80, 64'd0,
        TYPED, 64'hFFFF_FFFF_FFFF_FF80},
      '{gcdlcm_pkg::KIND_GCD, 1'b1, gcdlcm_pkg::WCODE_64, 64'h8000_0000_0000_0000, 64'd0,
        TYPED, 64'h8000_0000_0000_0000},
      '{gcdlcm_pkg::KIND_GCD, 1'b1, gcdlcm_pkg::WCODE_64,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        TYPED, 64'h8000_0000_0000_0000},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_8,  64'h80, 64'h80, PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_32, 64'h8000_0000, 64'h8000_0000,
        PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_GCD, 1'b1, gcdlcm_pkg::WCODE_32, 64'h8000_0000, 64'h4000_0000,
        PREDICT, 64'd0},
      // saturation, both signs and unsigned
      '{gcdlcm_pkg::KIND_LCM, 1'b0, gcdlcm_pkg::WCODE_8,  64'hFF, 64'hFE, TYPED, 64'hFF},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_8,  64'd127, 64'd126, TYPED, 64'h7F},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_8,  64'h80, 64'd3,
        TYPED, 64'hFFFF_FFFF_FFFF_FF80},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_64,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
        TYPED, 64'h7FFF_FFFF_FFFF_FFFF},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_64, 64'h8000_0000_0000_0000, 64'd3,
        TYPED, 64'h8000_0000_0000_0000},
      '{gcdlcm_pkg::KIND_LCM, 1'b0, gcdlcm_pkg::WCODE_64, '1, 64'hFFFF_FFFF_FFFF_FFFE,
        TYPED, '1},
      // upper bits ignored, ordinary values, mixed signs
      '{gcdlcm_pkg::KIND_GCD, 1'b0, gcdlcm_pkg::WCODE_8,
        64'hDEAD_BEEF_0000_000C, 64'hFFFF_FFFF_FFFF_FF12,
        PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b0, gcdlcm_pkg::WCODE_16, 64'd4,  64'd6,  PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_16, 64'hFFFC, 64'd6, PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b1, gcdlcm_pkg::WCODE_16, 64'hFFFA, 64'hFFFC,
        PREDICT, 64'd0},
      '{gcdlcm_pkg::KIND_LCM, 1'b0, gcdlcm_pkg::WCODE_32, 64'hFFFF_FFFF, 64'd1,
        PREDICT, 64'd0}
   };

   gcd_lcm_unit_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_is_signed    (req_is_signed),
      .req_width_code   (req_width_code),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value)
   );

   // clock, 8 ns period
   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [gcdlcm_pkg::PORT_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // gcd of magnitudes, or lcm with saturation, at the selected width
   function automatic logic [gcdlcm_pkg::PORT_W-1:0] gcd_lcm_of(
         input logic                            k,
         input logic                            s,
         input logic [gcdlcm_pkg::WCODE_W-1:0]  wc,
         input logic [gcdlcm_pkg::PORT_W-1:0]   a_in,
         input logic [gcdlcm_pkg::PORT_W-1:0]   b_in);
      int unsigned                     w;
      logic [gcdlcm_pkg::PORT_W-1:0]   m, top, a, b, ma, mb, x, y, r, mq, p, ceiling, res;
      logic                            na, nb, ng, neg;
      w   = 8 << wc;
      m   = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      top = 64'd1 << (w - 1);
      a   = a_in & m;
      b   = b_in & m;
      na  = s && ((a & top) != 0);
      nb  = s && ((b & top) != 0);
      ma  = na ? (64'd0 - (a | ~m)) : a;
      mb  = nb ? (64'd0 - (b | ~m)) : b;
      // Euclid on the magnitudes
      x = ma;
      y = mb;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      if (k == gcdlcm_pkg::KIND_GCD) begin
         res = x & m;
      end else if (a == 0 || b == 0) begin
         res = '0;
      end else begin
         // a gcd of 2^(w-1) reads as negative when signed
         ng      = s && ((x & top) != 0);
         mq      = ma / x;
         neg     = s && ((na != ng) != nb);
         ceiling = s ? (neg ? top : top - 64'd1) : m;
         if (mq > ceiling / mb) begin
            res = ceiling;
         end else begin
            p   = mq * mb;
            res = (neg ? (64'd0 - p) : p) & m;
         end
      end
      return (s && ((res & top) != 0)) ? (res | ~m) : (res & m);
   endfunction

   // operand with a spread of shapes: raw bits, multiples of a shared factor,
   // small magnitudes, edge values; sometimes negated, sometimes with junk above w
   function automatic logic [gcdlcm_pkg::PORT_W-1:0] make_operand(
         input logic [gcdlcm_pkg::WCODE_W-1:0]  wc,
         input logic [gcdlcm_pkg::PORT_W-1:0]   factor);
      int unsigned                     w;
      logic [gcdlcm_pkg::PORT_W-1:0]   m, top, v;
      w   = 8 << wc;
      m   = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      top = 64'd1 << (w - 1);
      case ($urandom_range(0, 9))
         0, 1, 2:    v = rand_word();
         3, 4, 5, 6: v = factor * (rand_word() >> (64 - w / 2));
         7:          v = rand_word() >> $urandom_range(0, 63);
         8: begin
            case ($urandom_range(0, 5))
               0:       v = '0;
               1:       v = 64'd1;
               2:       v = top;
               3:       v = top - 64'd1;
               4:       v = m;
               default: v = top + 64'd1;
            endcase
         end
         default:    v = factor;
      endcase
      if ($urandom_range(0, 3) == 0)
         v = 64'd0 - v;
      if ($urandom_range(0, 1) == 0)
         v = (v & m) | (rand_word() & ~m);
      else
         v = v & m;
      return v;
   endfunction

   // present a word and hold it until taken, then log what should come back
   task automatic send_word(input logic k, input logic s,
                            input logic [gcdlcm_pkg::WCODE_W-1:0] wc,
                            input logic [gcdlcm_pkg::PORT_W-1:0] a,
                            input logic [gcdlcm_pkg::PORT_W-1:0] b,
                            input logic typed,
                            input logic [gcdlcm_pkg::PORT_W-1:0] typed_val);
      start          <= 1'b1;
      req_kind       <= k;
      req_is_signed  <= s;
      req_width_code <= wc;
      req_operand_a  <= a;
      req_operand_b  <= b;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? typed_val : gcd_lcm_of(k, s, wc, a, b));
   endtask

   // drop start for an idle gap, with junk on the fields meanwhile; a zero n leaves all as is
   task automatic idle_for(input int n);
      if (n > 0) begin
         start          <= 1'b0;
         req_kind       <= 1'($urandom_range(0, 1));
         req_is_signed  <= 1'($urandom_range(0, 1));
         req_width_code <= gcdlcm_pkg::WCODE_W'($urandom_range(0, 3));
         req_operand_a  <= rand_word();
         req_operand_b  <= rand_word();
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // random gap: mostly none or short, a few long, rarely a wait for all results
   task automatic sender_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         idle_for(0);
      else if (sel < 85)
         idle_for($urandom_range(1, 3));
      else if (sel < 97)
         idle_for($urandom_range(4, 20));
      else if (sel < 99)
         idle_for($urandom_range(30, 250));
      else
         wait_for_drain();
   endtask

   // result checker: every strobe must match the oldest pending word
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_ERRORS)
               $display("%0t: result %h with nothing pending", $realtime, rsp_result_value);
         end else begin
            wanted = pending_results.pop_front();
            if (rsp_result_value !== wanted) begin
               fail_count++;
               if (fail_count <= SHOWN_ERRORS)
                  $display("%0t: result_value expected %h got %h",
                           $realtime, wanted, rsp_result_value);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic                             k, s;
      logic [gcdlcm_pkg::WCODE_W-1:0]   wc;
      logic [gcdlcm_pkg::PORT_W-1:0]    factor, a, b;
      fail_count     = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = gcdlcm_pkg::KIND_GCD;
      req_is_signed  = 1'b0;
      req_width_code = gcdlcm_pkg::WCODE_8;
      req_operand_a  = '0;
      req_operand_b  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].kind, directed_rows[i].sgn, directed_rows[i].wc,
                   directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].typed, directed_rows[i].want);
         sender_gap();
      end
      wait_for_drain();

      // random words; a shared factor gives lcm results short of saturation
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         k      = 1'($urandom_range(0, 1));
         s      = 1'($urandom_range(0, 1));
         wc     = gcdlcm_pkg::WCODE_W'($urandom_range(0, 3));
         factor = rand_word() >> (64 - (8 << wc) / 2);
         a      = make_operand(wc, factor);
         b      = make_operand(wc, factor);
         send_word(k, s, wc, a, b, PREDICT, '0);
         sender_gap();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
